[rtl/periodic_task_deadline_scheduler_top_defines.svh]
// Assertion macros for the periodic task deadline scheduler checker.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef PERIODIC_TASK_DEADLINE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_DEADLINE_SCHEDULER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptds_pkg.sv]
// Shared constants, codes and payload types of the periodic task deadline scheduler.
// Used by the top level and by the port checker; depends on nothing else.
`default_nettype none

package ptds_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
    localparam int TIME_W    = 48;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 32;

    localparam logic [15:0] SPIN_TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] SLEEP_MAX          = 16'hFFFF;
    localparam logic [7:0]  TASKS_SAT          = 8'd255;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_PAUSE  = 3'd1;
    localparam logic [2:0] MODE_START  = 3'd2;
    localparam logic [2:0] MODE_PERIOD = 3'd3;
    localparam logic [2:0] MODE_SCAN   = 3'd4;

    localparam logic [3:0] KIND_DISPATCH      = 4'd0;
    localparam logic [3:0] KIND_SPINNING      = 4'd1;
    localparam logic [3:0] KIND_SLEEP_FOREVER = 4'd2;
    localparam logic [3:0] KIND_SLEEP_FOR     = 4'd3;
    localparam logic [3:0] KIND_NO_SLEEP      = 4'd4;
    localparam logic [3:0] KIND_ADDED         = 4'd5;
    localparam logic [3:0] KIND_FULL          = 4'd6;
    localparam logic [3:0] KIND_DONE          = 4'd7;
    localparam logic [3:0] KIND_BAD_INDEX     = 4'd8;

    typedef struct packed {
        logic [1:0]        pad;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] now_ms;
        logic              has_runner;
        logic              start_paused;
        logic [TIME_W-1:0] deadline_ms;
        logic [15:0]       value_ms;
        logic [3:0]        task_index;
    } item_t;

    typedef struct packed {
        logic [3:0]        pad;
        logic signed [7:0] provisioning;
        logic [15:0]       sleep_len;
        logic [3:0]        task_index_res;
    } result_t;

endpackage

`default_nettype wire

[rtl/periodic_task_deadline_scheduler_top.sv]
// Periodic task deadline scheduler: slot table, command handling and scan sequencer.
// Depends on ptds_pkg for constants, codes and payload types.
//
// Channel  Direction  Contents
// s_axis   in         tuser: mode; tdata: task command and time sample
// m_axis   out        tuser: kind; tdata: slot, sleep, provisioning; tlast: final result
// cfg      in         cfg_wr_en, cfg_wr_data: spin timeout in microseconds
//
// Add, pause, start and set period pass from the transfer into the execute state, which
// waits while a result is held; their result is registered when that state ends.
// A scan arms, passes one slot per cycle through the shared 48-bit comparator and adder
// unless a due slot waits on a held result, finishes, and re-arms unless it is spinning.
// A result that waits in the output register stalls only the next result, not the
// next input transfer. Reset is synchronous; the slot table needs no clearing pass.
`default_nettype none

module periodic_task_deadline_scheduler_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, lowest bit up: task_index, value_ms, deadline_ms, start_paused,
    // has_runner, now_ms, now_us, zero fill.
    input  wire logic [ptds_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode.
    input  wire logic [2:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata, lowest bit up: task_index_res, sleep_len, provisioning, zero fill.
    output logic [ptds_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // tuser: kind.
    output logic [3:0]                           m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [15:0]                     cfg_wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_REARM  = 3'd4;

    localparam int SLOT_W  = ptds_pkg::SLOT_W;
    localparam int COUNT_W = ptds_pkg::COUNT_W;
    localparam int TIME_W  = ptds_pkg::TIME_W;

    logic [2:0]              state_reg, state_next;
    logic [7:0]              tasks_added_reg, tasks_added_next;
    logic [TIME_W-1:0]       spin_deadline_reg, spin_deadline_next;
    logic                    spin_armed_reg, spin_armed_next;
    logic [15:0]             spin_timeout_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    dispatched_reg, dispatched_next;
    logic                    have_next_reg, have_next_next;

    ptds_pkg::item_t         item_reg, item_next;
    logic [2:0]              mode_reg, mode_next;
    logic [3:0]              out_kind_reg, out_kind_next;
    ptds_pkg::result_t       out_res_reg, out_res_next;
    logic                    out_last_reg, out_last_next;
    logic [TIME_W-1:0]       next_dl_reg, next_dl_next;
    logic [SLOT_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [SLOT_W-1:0]       scan_idx_reg, scan_idx_next;

    logic [TIME_W-1:0]       deadline_reg [ptds_pkg::MAX_TASKS];
    logic                    paused_reg   [ptds_pkg::MAX_TASKS];
    logic                    runnable_reg [ptds_pkg::MAX_TASKS];
    logic [15:0]             period_reg   [ptds_pkg::MAX_TASKS];

    logic                    dl_we, paused_we, runnable_we, period_we;
    logic [SLOT_W-1:0]       wr_slot;
    logic [TIME_W-1:0]       dl_wdata;
    logic                    paused_wdata;
    logic [15:0]             period_wdata;

    logic [TIME_W-1:0]       add_a, add_b;
    logic                    add_sub;
    logic [TIME_W:0]         add_sum;
    logic [TIME_W-1:0]       cmp_a, cmp_b;
    logic                    cmp_lt;

    logic                    out_free;
    logic [COUNT_W-1:0]      used_slots;
    logic                    idx_ok;
    logic                    scan_last;
    logic [TIME_W-1:0]       dl_rd;
    logic                    active;
    logic                    due;
    logic [SLOT_W-1:0]       cmd_slot;
    logic [SLOT_W-1:0]       add_slot;
    logic                    room;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign used_slots = (tasks_added_reg >= 8'(ptds_pkg::MAX_TASKS)) ?
                        COUNT_W'(ptds_pkg::MAX_TASKS) : COUNT_W'(tasks_added_reg);
    assign idx_ok     = {4'd0, item_reg.task_index} < 8'(used_slots);
    assign scan_last  = (COUNT_W'(scan_idx_reg) + COUNT_W'(1)) == used_slots;
    assign cmd_slot   = SLOT_W'(item_reg.task_index);
    assign add_slot   = SLOT_W'(tasks_added_reg);
    assign room       = tasks_added_reg < 8'(ptds_pkg::MAX_TASKS);

    assign dl_rd  = deadline_reg[scan_idx_reg];
    assign active = runnable_reg[scan_idx_reg] && !paused_reg[scan_idx_reg];
    assign due    = active && !cmp_lt;

    // Shared adder and comparator, steered by the sequencer state.
    always_comb begin
        add_a   = item_reg.now_us;
        add_b   = TIME_W'(spin_timeout_reg);
        add_sub = 1'b0;
        cmp_a   = item_reg.now_us;
        cmp_b   = spin_deadline_reg;
        case (state_reg)
            ST_EXEC: begin
                if (mode_reg == ptds_pkg::MODE_START) begin
                    add_a = item_reg.now_ms;
                    add_b = TIME_W'(item_reg.value_ms);
                end
            end
            ST_SCAN: begin
                add_a = item_reg.now_ms;
                add_b = TIME_W'(period_reg[scan_idx_reg]);
                cmp_a = item_reg.now_ms;
                cmp_b = dl_rd;
            end
            ST_FINISH: begin
                add_a   = next_dl_reg;
                add_b   = item_reg.now_ms;
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                  + {{TIME_W{1'b0}}, add_sub};
        cmp_lt  = cmp_a < cmp_b;
    end

    always_comb begin
        state_next         = state_reg;
        tasks_added_next   = tasks_added_reg;
        spin_deadline_next = spin_deadline_reg;
        spin_armed_next    = spin_armed_reg;
        dispatched_next    = dispatched_reg;
        have_next_next     = have_next_reg;
        item_next          = item_reg;
        mode_next          = mode_reg;
        next_dl_next       = next_dl_reg;
        pend_idx_next      = pend_idx_reg;
        scan_idx_next      = scan_idx_reg;

        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_kind_next      = out_kind_reg;
        out_last_next      = out_last_reg;
        out_res_next       = out_res_reg;

        dl_we        = 1'b0;
        paused_we    = 1'b0;
        runnable_we  = 1'b0;
        period_we    = 1'b0;
        wr_slot      = cmd_slot;
        dl_wdata     = add_sum[TIME_W-1:0];
        paused_wdata = 1'b1;
        period_wdata = item_reg.value_ms;

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    item_next  = ptds_pkg::item_t'(s_axis_tdata);
                    mode_next  = s_axis_tuser;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (mode_reg == ptds_pkg::MODE_SCAN) begin
                    if (!spin_armed_reg) begin
                        spin_deadline_next = add_sum[TIME_W-1:0];
                        spin_armed_next    = 1'b1;
                    end
                    dispatched_next = 1'b0;
                    have_next_next  = 1'b0;
                    scan_idx_next   = '0;
                    state_next      = (used_slots == '0) ? ST_FINISH : ST_SCAN;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_res_next.task_index_res = '0;
                    state_next     = ST_IDLE;
                    case (mode_reg)
                        ptds_pkg::MODE_ADD: begin
                            wr_slot      = add_slot;
                            dl_wdata     = item_reg.deadline_ms;
                            paused_wdata = item_reg.start_paused;
                            dl_we        = room;
                            paused_we    = room;
                            runnable_we  = room;
                            period_we    = room;
                            if (tasks_added_reg != ptds_pkg::TASKS_SAT) begin
                                tasks_added_next = tasks_added_reg + 8'd1;
                            end
                            if (room) begin
                                out_kind_next = ptds_pkg::KIND_ADDED;
                                out_res_next.task_index_res = 4'(add_slot);
                            end else begin
                                out_kind_next = ptds_pkg::KIND_FULL;
                            end
                        end
                        ptds_pkg::MODE_PAUSE, ptds_pkg::MODE_START,
                        ptds_pkg::MODE_PERIOD: begin
                            if (idx_ok) begin
                                out_kind_next = ptds_pkg::KIND_DONE;
                                if (mode_reg == ptds_pkg::MODE_PAUSE) begin
                                    paused_we = 1'b1;
                                end else if (mode_reg == ptds_pkg::MODE_START) begin
                                    dl_we        = 1'b1;
                                    paused_we    = 1'b1;
                                    paused_wdata = 1'b0;
                                end else begin
                                    period_we = 1'b1;
                                end
                            end else begin
                                out_kind_next = ptds_pkg::KIND_BAD_INDEX;
                            end
                        end
                        default: begin
                            out_kind_next = ptds_pkg::KIND_BAD_INDEX;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!(due && dispatched_reg && !out_free)) begin
                    if (active && cmp_lt && !dispatched_reg &&
                        (!have_next_reg || dl_rd < next_dl_reg)) begin
                        next_dl_next   = dl_rd;
                        have_next_next = 1'b1;
                    end
                    if (due) begin
                        wr_slot = scan_idx_reg;
                        dl_we   = 1'b1;
                        if (dispatched_reg) begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_kind_next  = ptds_pkg::KIND_DISPATCH;
                            out_res_next.task_index_res = 4'(pend_idx_reg);
                        end
                        pend_idx_next   = scan_idx_reg;
                        dispatched_next = 1'b1;
                    end
                    if (scan_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        scan_idx_next = scan_idx_reg + SLOT_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_res_next.task_index_res = '0;
                    state_next     = ST_REARM;
                    if (dispatched_reg) begin
                        out_kind_next = ptds_pkg::KIND_DISPATCH;
                        out_res_next.task_index_res = 4'(pend_idx_reg);
                    end else if (cmp_lt) begin
                        out_kind_next = ptds_pkg::KIND_SPINNING;
                        state_next    = ST_IDLE;
                    end else if (!have_next_reg) begin
                        out_kind_next = ptds_pkg::KIND_SLEEP_FOREVER;
                    end else if (add_sum[TIME_W] && (add_sum[TIME_W-1:0] != '0)) begin
                        out_kind_next = ptds_pkg::KIND_SLEEP_FOR;
                        if (add_sum[TIME_W-1:16] != '0) begin
                            out_res_next.sleep_len = ptds_pkg::SLEEP_MAX;
                        end else begin
                            out_res_next.sleep_len = add_sum[15:0];
                        end
                    end else begin
                        out_kind_next = ptds_pkg::KIND_NO_SLEEP;
                    end
                end
            end
            ST_REARM: begin
                spin_deadline_next = add_sum[TIME_W-1:0];
                state_next         = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_valid_next && !(out_valid_reg && !m_axis_tready)) begin
            out_res_next.pad          = '0;
            out_res_next.provisioning =
                $signed(8'(ptds_pkg::MAX_TASKS) - tasks_added_next);
            if (out_kind_next != ptds_pkg::KIND_SLEEP_FOR) begin
                out_res_next.sleep_len = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            tasks_added_reg   <= '0;
            spin_deadline_reg <= '0;
            spin_armed_reg    <= 1'b0;
            spin_timeout_reg  <= ptds_pkg::SPIN_TIMEOUT_RESET;
            out_valid_reg     <= 1'b0;
            dispatched_reg    <= 1'b0;
            have_next_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            tasks_added_reg   <= tasks_added_next;
            spin_deadline_reg <= spin_deadline_next;
            spin_armed_reg    <= spin_armed_next;
            out_valid_reg     <= out_valid_next;
            dispatched_reg    <= dispatched_next;
            have_next_reg     <= have_next_next;
            if (cfg_wr_en) begin
                spin_timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        mode_reg     <= mode_next;
        out_kind_reg <= out_kind_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        next_dl_reg  <= next_dl_next;
        pend_idx_reg <= pend_idx_next;
        scan_idx_reg <= scan_idx_next;
        if (dl_we) begin
            deadline_reg[wr_slot] <= dl_wdata;
        end
        if (paused_we) begin
            paused_reg[wr_slot] <= paused_wdata;
        end
        if (runnable_we) begin
            runnable_reg[wr_slot] <= item_reg.has_runner;
        end
        if (period_we) begin
            period_reg[wr_slot] <= period_wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/ptds_checker.sv]
// Port-level checker for the periodic task deadline scheduler, bound to the top level.
// Depends on ptds_pkg and on periodic_task_deadline_scheduler_top_defines.svh.
`default_nettype none

`include "periodic_task_deadline_scheduler_top_defines.svh"

module ptds_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [ptds_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [3:0]                     m_axis_tuser,
    input wire logic                           m_axis_tlast
);

    ptds_pkg::result_t m_res;
    logic              s_fire;

    assign m_res  = ptds_pkg::result_t'(m_axis_tdata);
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // Each input transfer is worked on alone, so the input side closes right after it.
    `PTDS_ASSERT_NXT(a_busy_after_transfer, s_fire, !s_axis_tready,
                     "input taken while busy")

    // Only dispatch results can be followed by further results of the same item.
    `PTDS_ASSERT_IMP(a_only_dispatch_continues, m_axis_tvalid && !m_axis_tlast,
                     m_axis_tuser == ptds_pkg::KIND_DISPATCH,
                     "non-final result is not a dispatch")

    // The slot field is zero unless a slot was dispatched or filled.
    `PTDS_ASSERT_IMP(a_slot_zero,
                     m_axis_tvalid && m_axis_tuser != ptds_pkg::KIND_DISPATCH
                     && m_axis_tuser != ptds_pkg::KIND_ADDED,
                     m_res.task_index_res == '0, "slot set on a result without a slot")

    // A sleep length is reported only with a timed sleep request.
    `PTDS_ASSERT_IMP(a_sleep_only_timed, m_axis_tvalid && m_axis_tuser != ptds_pkg::KIND_SLEEP_FOR,
                     m_res.sleep_len == '0, "sleep length on a result without a timed sleep")

    // A stalled result holds its payload.
    `PTDS_ASSERT_NXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                     "stalled result changed")

endmodule

bind periodic_task_deadline_scheduler_top ptds_checker u_ptds_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
